### rtl/tlcs_pkg.sv
// ----------------------------------------------------------------------------
// Threshold link cluster select package
// Shared sizes, state machine type and configuration register indexes.
// ----------------------------------------------------------------------------
package tlcs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int MAX_DIMS   = 20;
   localparam int COORD_BITS = 24;

   localparam int PT_BITS    = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int COL_BITS   = $clog2(MAX_DIMS + 1);
   localparam int DIM_BITS   = 5;
   localparam int ADDR_BITS  = $clog2(MAX_POINTS * MAX_DIMS);
   localparam int MAG_BITS   = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + $clog2(MAX_DIMS + 1);
   localparam int THR_BITS   = 23;
   localparam int THR2_BITS  = 2 * THR_BITS;
   localparam int PC_BITS    = 32;
   localparam int RSP_BITS   = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LINK_ISSUE,
      ST_LINK_DRAIN,
      ST_PATH_ROW,
      ST_PATH_SCAN,
      ST_PATH_WRITE,
      ST_MEM_ROW,
      ST_MEM_APPLY,
      ST_OUT,
      ST_OUT_WAIT
   } state_type;

   typedef enum logic [0:0] {
      CSR_DIMENSIONS     = 1'b0,
      CSR_LINK_THRESHOLD = 1'b1
   } csr_index_type;

endpackage

### rtl/threshold_link_cluster_select_top.sv
// ----------------------------------------------------------------------------
// Threshold link cluster select
// Loads points one coordinate per transfer, links close pairs, selects the
// root with the most forward paths and emits one membership flag per point.
// ----------------------------------------------------------------------------
// Loading takes one coordinate per cycle while idle; the first coordinate of a
// point also starts a row clear of the store, which holds req_tready low.
// Clustering N points of D coordinates then streams the coordinates of every
// pair through the shared squared-distance unit, counts forward paths, marks
// membership and ends with N result transfers.
// Reset is synchronous; it restores dimensions 1 and threshold 0.
module threshold_link_cluster_select_top
   import tlcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [COORD_BITS-1:0] req_tdata,   // coord
   input  logic                  req_tlast,   // last_in_set
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_BITS-1:0]   rsp_tdata,   // point_index, in_cluster, zero pad
   output logic                  rsp_tlast,   // last_result
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [THR_BITS-1:0]   csr_data
);

   logic signed [COORD_BITS-1:0] coord_mem [MAX_POINTS*MAX_DIMS];
   logic [MAX_POINTS-1:0]        link_mem  [MAX_POINTS];
   logic [PC_BITS-1:0]           pc_mem    [MAX_POINTS];

   state_type              state_ff, state_in;
   logic [DIM_BITS-1:0]    dims_ff, dims_in;
   logic [THR_BITS-1:0]    thr_ff, thr_in;
   logic [THR2_BITS-1:0]   thr2_ff;
   logic [COL_BITS-1:0]    pos_ff, pos_in;
   logic [CNT_BITS-1:0]    pl_ff, pl_in;
   logic [CNT_BITS-1:0]    n_ff, n_in;
   logic [PT_BITS-1:0]     clr_row_ff, clr_row_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic                   last_pend_ff, last_pend_in;

   logic [PT_BITS-1:0]     ii_ff, ii_in;
   logic [PT_BITS-1:0]     jj_ff, jj_in;
   logic [COL_BITS-1:0]    kk_ff, kk_in;

   logic                   v1_ff, v1_in, v2_ff, v3_ff;
   logic                   first1_ff, first1_in, first2_ff, first3_ff;
   logic                   lastk1_ff, lastk1_in, lastk2_ff, lastk3_ff;
   logic                   lastj1_ff, lastj1_in, lastj2_ff, lastj3_ff;
   logic [PT_BITS-1:0]     i1_ff, i1_in, i2_ff, i3_ff;
   logic [PT_BITS-1:0]     j1_ff, j1_in, j2_ff, j3_ff;
   logic signed [COORD_BITS-1:0] rda_ff, rdb_ff;
   logic [MAG_BITS-1:0]    mag_ff;
   logic [SQ_BITS-1:0]     sq_ff;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [MAX_POINTS-1:0]  row_acc_ff, row_acc_in;

   logic [PT_BITS-1:0]     i_ff, i_in;
   logic [CNT_BITS-1:0]    j_ff, j_in;
   logic [PC_BITS-1:0]     acc_ff, acc_in;
   logic [PC_BITS-1:0]     best_ff, best_in;
   logic [PT_BITS-1:0]     root_ff, root_in;
   logic                   pcv_ff, pcv_in;
   logic                   pbit_ff, pbit_in;
   logic [PC_BITS-1:0]     prd_ff;
   logic [MAX_POINTS-1:0]  lrd_ff;
   logic [MAX_POINTS-1:0]  member_ff, member_in;
   logic [MAX_POINTS-1:0]  row_mask;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PT_BITS-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                   rsp_flag_ff, rsp_flag_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [DIM_BITS-1:0]    dims_act;
   logic [COL_BITS-1:0]    pos0, pos1;
   logic [CNT_BITS-1:0]    pl0, pl1, n_load;
   logic                   load_wr;
   logic                   cwe;
   logic [ADDR_BITS-1:0]   caddr, a_addr, b_addr;
   logic signed [COORD_BITS-1:0] cwdata;
   logic                   lwe;
   logic [MAX_POINTS-1:0]  lwdata;
   logic                   pwe;
   logic                   go;
   logic [CNT_BITS-1:0]    n_go;
   logic [MAG_BITS-1:0]    diff;
   logic [SUM_BITS-1:0]    sum_new;
   logic                   linked;
   logic [PC_BITS+1:0]     psum;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS-PT_BITS-1){1'b0}}, rsp_flag_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (dims_ff == '0) begin
         dims_act = DIM_BITS'(1);
      end else if (dims_ff > DIM_BITS'(MAX_DIMS)) begin
         dims_act = DIM_BITS'(MAX_DIMS);
      end else begin
         dims_act = dims_ff;
      end
   end

   always_comb begin
      pos0 = pos_ff;
      pl0  = pl_ff;
      if (COL_BITS'(dims_act) <= pos_ff) begin
         pos0 = '0;
         if (pl_ff < CNT_BITS'(MAX_POINTS)) begin
            pl0 = pl_ff + 1'b1;
         end
      end
      load_wr = (pl0 < CNT_BITS'(MAX_POINTS));
      pos1 = pos0;
      pl1  = pl0;
      if (load_wr) begin
         pos1 = pos0 + 1'b1;
         if (pos1 >= COL_BITS'(dims_act)) begin
            pos1 = '0;
            pl1  = pl0 + 1'b1;
         end
      end
      n_load = pl1 + CNT_BITS'((pos1 != '0) && (pl1 < CNT_BITS'(MAX_POINTS)));
   end

   always_comb begin
      diff    = MAG_BITS'(rda_ff) - MAG_BITS'(rdb_ff);
      diff    = ($signed(MAG_BITS'({rda_ff[COORD_BITS-1], rda_ff}))
                 - $signed(MAG_BITS'({rdb_ff[COORD_BITS-1], rdb_ff})) < 0)
                ? MAG_BITS'(-diff) : diff;
      sum_new = (first3_ff ? '0 : sum_ff) + SUM_BITS'(sq_ff);
      linked  = (sum_new < SUM_BITS'(thr2_ff));
      psum    = (PC_BITS+2)'(acc_ff) + (PC_BITS+2)'(prd_ff) + (PC_BITS+2)'(1);
      for (int b = 0; b < MAX_POINTS; b++) begin
         row_mask[b] = (b > int'(i_ff)) && (b < int'(n_ff));
      end
   end

   always_comb begin
      state_in     = state_ff;
      dims_in      = dims_ff;
      thr_in       = thr_ff;
      pos_in       = pos_ff;
      pl_in        = pl_ff;
      n_in         = n_ff;
      clr_row_in   = clr_row_ff;
      col_in       = col_ff;
      last_pend_in = last_pend_ff;
      ii_in        = ii_ff;
      jj_in        = jj_ff;
      kk_in        = kk_ff;
      v1_in        = 1'b0;
      first1_in    = first1_ff;
      lastk1_in    = lastk1_ff;
      lastj1_in    = lastj1_ff;
      i1_in        = i1_ff;
      j1_in        = j1_ff;
      sum_in       = sum_ff;
      row_acc_in   = row_acc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      root_in      = root_ff;
      pcv_in       = 1'b0;
      pbit_in      = pbit_ff;
      member_in    = member_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_last_in  = rsp_last_ff;
      cwe          = 1'b0;
      caddr        = ADDR_BITS'(pl0[PT_BITS-1:0]) * ADDR_BITS'(MAX_DIMS) + ADDR_BITS'(pos0);
      cwdata       = req_tdata;
      a_addr       = ADDR_BITS'(ii_ff) * ADDR_BITS'(MAX_DIMS) + ADDR_BITS'(kk_ff);
      b_addr       = ADDR_BITS'(jj_ff) * ADDR_BITS'(MAX_DIMS) + ADDR_BITS'(kk_ff);
      lwe          = 1'b0;
      lwdata       = row_acc_ff;
      pwe          = 1'b0;
      go           = 1'b0;
      n_go         = n_ff;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIMENSIONS:     dims_in = csr_data[DIM_BITS-1:0];
            CSR_LINK_THRESHOLD: thr_in  = csr_data;
            default: ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (v3_ff) begin
         sum_in = sum_new;
         if (lastk3_ff) begin
            if (linked) begin
               row_acc_in[j3_ff] = 1'b1;
            end
            if (lastj3_ff) begin
               lwe        = 1'b1;
               lwdata     = row_acc_in;
               row_acc_in = '0;
            end
         end
      end

      if (pcv_ff && pbit_ff) begin
         acc_in = (psum[PC_BITS+1:PC_BITS] != '0) ? '1 : psum[PC_BITS-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cwe = load_wr;
               if (req_tlast) begin
                  pos_in = '0;
                  pl_in  = '0;
                  n_in   = n_load;
               end else begin
                  pos_in = pos1;
                  pl_in  = pl1;
               end
               if (load_wr && (pos0 == '0) && (MAX_DIMS > 1)) begin
                  clr_row_in   = pl0[PT_BITS-1:0];
                  col_in       = COL_BITS'(1);
                  last_pend_in = req_tlast;
                  state_in     = ST_CLEAR;
               end else if (req_tlast) begin
                  go   = 1'b1;
                  n_go = n_load;
               end
            end
         end
         ST_CLEAR: begin
            cwe    = 1'b1;
            caddr  = ADDR_BITS'(clr_row_ff) * ADDR_BITS'(MAX_DIMS) + ADDR_BITS'(col_ff);
            cwdata = '0;
            if (col_ff == COL_BITS'(MAX_DIMS - 1)) begin
               if (last_pend_ff) begin
                  go = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_LINK_ISSUE: begin
            v1_in     = 1'b1;
            first1_in = (kk_ff == '0);
            lastk1_in = (kk_ff == COL_BITS'(dims_act - 1'b1));
            lastj1_in = ({1'b0, jj_ff} == n_ff - 1'b1);
            i1_in     = ii_ff;
            j1_in     = jj_ff;
            if (lastk1_in) begin
               kk_in = '0;
               if (lastj1_in) begin
                  if ({1'b0, ii_ff} == n_ff - CNT_BITS'(2)) begin
                     state_in = ST_LINK_DRAIN;
                  end else begin
                     ii_in = ii_ff + 1'b1;
                     jj_in = ii_ff + PT_BITS'(2);
                  end
               end else begin
                  jj_in = jj_ff + 1'b1;
               end
            end else begin
               kk_in = kk_ff + 1'b1;
            end
         end
         ST_LINK_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               i_in     = PT_BITS'(n_ff - 1'b1);
               acc_in   = '0;
               best_in  = '0;
               root_in  = '0;
               state_in = ST_PATH_ROW;
            end
         end
         ST_PATH_ROW: begin
            j_in     = CNT_BITS'(i_ff) + 1'b1;
            state_in = ST_PATH_SCAN;
         end
         ST_PATH_SCAN: begin
            if (j_ff < n_ff) begin
               pcv_in  = 1'b1;
               pbit_in = lrd_ff[j_ff[PT_BITS-1:0]];
               j_in    = j_ff + 1'b1;
            end else begin
               state_in = ST_PATH_WRITE;
            end
         end
         ST_PATH_WRITE: begin
            pwe = 1'b1;
            if (acc_ff >= best_ff) begin
               best_in = acc_ff;
               root_in = i_ff;
            end
            if (i_ff == '0) begin
               member_in = '0;
               if (acc_ff >= best_ff) begin
                  member_in[i_ff] = 1'b1;
                  i_in            = i_ff;
               end else begin
                  member_in[root_ff] = 1'b1;
                  i_in               = root_ff;
               end
               state_in = ST_MEM_ROW;
            end else begin
               i_in     = i_ff - 1'b1;
               acc_in   = '0;
               state_in = ST_PATH_ROW;
            end
         end
         ST_MEM_ROW: begin
            state_in = ST_MEM_APPLY;
         end
         ST_MEM_APPLY: begin
            if (member_ff[i_ff]) begin
               member_in = member_ff | (lrd_ff & row_mask);
            end
            if ({1'b0, i_ff} == n_ff - 1'b1) begin
               i_in     = '0;
               state_in = ST_OUT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_MEM_ROW;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = i_ff;
               rsp_flag_in  = member_ff[i_ff];
               rsp_last_in  = ({1'b0, i_ff} == n_ff - 1'b1);
               if (rsp_last_in) begin
                  state_in = ST_OUT_WAIT;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (go) begin
         n_in       = n_go;
         ii_in      = '0;
         jj_in      = PT_BITS'(1);
         kk_in      = '0;
         row_acc_in = '0;
         if (n_go >= CNT_BITS'(2)) begin
            state_in = ST_LINK_ISSUE;
         end else begin
            i_in     = '0;
            acc_in   = '0;
            best_in  = '0;
            root_in  = '0;
            state_in = ST_PATH_ROW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dims_ff      <= DIM_BITS'(1);
         thr_ff       <= '0;
         pos_ff       <= '0;
         pl_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         pcv_ff       <= 1'b0;
         member_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dims_ff      <= dims_in;
         thr_ff       <= thr_in;
         pos_ff       <= pos_in;
         pl_ff        <= pl_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         pcv_ff       <= pcv_in;
         member_ff    <= member_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      thr2_ff      <= THR2_BITS'(thr_ff) * THR2_BITS'(thr_ff);
      n_ff         <= n_in;
      clr_row_ff   <= clr_row_in;
      col_ff       <= col_in;
      last_pend_ff <= last_pend_in;
      ii_ff        <= ii_in;
      jj_ff        <= jj_in;
      kk_ff        <= kk_in;
      first1_ff    <= first1_in;
      lastk1_ff    <= lastk1_in;
      lastj1_ff    <= lastj1_in;
      i1_ff        <= i1_in;
      j1_ff        <= j1_in;
      first2_ff    <= first1_ff;
      lastk2_ff    <= lastk1_ff;
      lastj2_ff    <= lastj1_ff;
      i2_ff        <= i1_ff;
      j2_ff        <= j1_ff;
      first3_ff    <= first2_ff;
      lastk3_ff    <= lastk2_ff;
      lastj3_ff    <= lastj2_ff;
      i3_ff        <= i2_ff;
      j3_ff        <= j2_ff;
      mag_ff       <= diff;
      sq_ff        <= SQ_BITS'(mag_ff) * SQ_BITS'(mag_ff);
      sum_ff       <= sum_in;
      row_acc_ff   <= row_acc_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      root_ff      <= root_in;
      pbit_ff      <= pbit_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (cwe) begin
         coord_mem[caddr] <= cwdata;
      end
      rda_ff <= coord_mem[a_addr];
      rdb_ff <= coord_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      if (lwe) begin
         link_mem[i3_ff] <= lwdata;
      end
      lrd_ff <= link_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         pc_mem[i_ff] <= acc_ff;
      end
      prd_ff <= pc_mem[j_ff[PT_BITS-1:0]];
   end

endmodule
